// ===== rtl/trp_pkg.sv =====
// shared types and constants of the three-axis rate pid controller
// no dependencies; imported by every module of the block
package trp_pkg;

    localparam int AXES      = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 48;
    localparam int INTEG_W   = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAINS_Z = 2'd2;

    localparam logic signed [15:0] GYRO_LIMIT  = 16'sd8000;
    localparam logic signed [31:0] INTEG_LIMIT = 32'sd2097152;
    localparam logic signed [15:0] DRIVE_LIMIT = 16'sd500;
    localparam int DT_SHIFT = 11;

    typedef struct packed {
        logic [15:0] kd;
        logic [15:0] ki;
        logic [15:0] kp;
    } t_gains;

    typedef struct packed {
        logic start;
        logic clear;
        logic ack;
    } t_lane_ctl;

    typedef struct packed {
        logic              done;
        logic signed [9:0] drive;
    } t_lane_sts;

endpackage

// ===== rtl/trp_req_if.sv =====
// request channel of the rate pid controller: setpoints, gyro rates, timestamp
// valid/ready handshake; no dependencies
interface trp_req_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] setpoint_x;
    logic signed [15:0] setpoint_y;
    logic signed [15:0] setpoint_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [31:0]        current_time_us;
    logic               clear_state;

    modport source (
        output valid, setpoint_x, setpoint_y, setpoint_z,
        output gyro_x, gyro_y, gyro_z, current_time_us, clear_state,
        input  ready
    );
    modport sink (
        input  valid, setpoint_x, setpoint_y, setpoint_z,
        input  gyro_x, gyro_y, gyro_z, current_time_us, clear_state,
        output ready
    );
endinterface

// ===== rtl/trp_rsp_if.sv =====
// response channel of the rate pid controller: three clamped axis drives
// valid/ready handshake; no dependencies
interface trp_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] drive_x;
    logic signed [9:0] drive_y;
    logic signed [9:0] drive_z;

    modport source (output valid, drive_x, drive_y, drive_z, input ready);
    modport sink (input valid, drive_x, drive_y, drive_z, output ready);
endinterface

// ===== rtl/three_axis_rate_pid.sv =====
// three-axis rate pid controller, top level
// response valid once all lanes are done and the merge stage registers their drives
// one request in flight at a time, as each lane's single multiplier steps through
// its four products; a new request is taken while a response waits
// reset clears gains, last timestamp, integrators and error histories at once
// uses trp_pkg, trp_req_if, trp_rsp_if, trp_lane and trp_merge
module three_axis_rate_pid
    import trp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    trp_req_if.sink              i_req,
    trp_rsp_if.source            o_rsp
);

    logic               r_busy;
    logic [31:0]        r_last_time;
    t_gains             r_gains [AXES];

    logic               accept;
    logic               ack;
    logic [31:0]        dt;
    t_lane_ctl          lane_ctl;
    t_lane_sts [AXES-1:0] lane_sts;
    logic signed [15:0] sp_arr   [AXES];
    logic signed [15:0] gyro_arr [AXES];

    assign i_req.ready = !r_busy;
    assign accept      = i_req.valid & !r_busy;
    assign dt          = i_req.current_time_us - r_last_time;

    assign lane_ctl.start = accept;
    assign lane_ctl.clear = i_req.clear_state;
    assign lane_ctl.ack   = ack;

    assign sp_arr[0]   = i_req.setpoint_x;
    assign sp_arr[1]   = i_req.setpoint_y;
    assign sp_arr[2]   = i_req.setpoint_z;
    assign gyro_arr[0] = i_req.gyro_x;
    assign gyro_arr[1] = i_req.gyro_y;
    assign gyro_arr[2] = i_req.gyro_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_last_time <= '0;
            r_gains[0]  <= '0;
            r_gains[1]  <= '0;
            r_gains[2]  <= '0;
        end else begin
            if (accept) begin
                r_busy      <= 1'b1;
                r_last_time <= i_req.current_time_us;
            end else if (ack) begin
                r_busy <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GAINS_X: r_gains[0] <= i_cfg_data;
                    CFG_GAINS_Y: r_gains[1] <= i_cfg_data;
                    CFG_GAINS_Z: r_gains[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        trp_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_setpoint (sp_arr[a]),
            .i_gyro     (gyro_arr[a]),
            .i_dt       (dt),
            .i_gains    (r_gains[a]),
            .o_sts      (lane_sts[a])
        );
    end

    trp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (lane_sts),
        .o_ack   (ack),
        .o_rsp   (o_rsp)
    );

`ifndef ASSERT_OFF
    a_ack_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ack |-> r_busy)
        else $error("lane results merged with no request in flight");
    a_no_early_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !ack)
        else $error("lanes finished one cycle after the request");
`endif

endmodule

// ===== rtl/trp_lane.sv =====
// one axis of the rate pid controller: error, integrator, derivative history
// and a shared multiplier stepped over four products; uses trp_pkg
module trp_lane
    import trp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctl          i_ctl,
    input  logic signed [15:0] i_setpoint,
    input  logic signed [15:0] i_gyro,
    input  logic [31:0]        i_dt,
    input  t_gains             i_gains,
    output t_lane_sts          o_sts
);

    typedef enum logic [2:0] {
        S_IDLE, S_ERR, S_MDT, S_MKI, S_MKP, S_MKD, S_SUM, S_DONE
    } t_state;

    t_state                     r_state;
    logic signed [15:0]         r_sp;
    logic signed [15:0]         r_gyro;
    logic [31:0]                r_dt;
    logic signed [15:0]         r_prior;
    logic signed [INTEG_W-1:0]  r_integ;
    logic signed [16:0]         r_dp1;
    logic signed [16:0]         r_dp2;
    logic signed [15:0]         r_e;
    logic signed [18:0]         r_dsum;
    logic signed [31:0]         r_prod;
    logic signed [15:0]         r_p;
    logic signed [9:0]          r_drive;

    logic signed [15:0] g;
    logic signed [16:0] diff;
    logic signed [15:0] e;
    logic signed [16:0] d0;
    logic signed [18:0] dsum;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] prod_full;
    logic signed [31:0] integ_sum;
    logic signed [31:0] integ_clamped;
    logic signed [15:0] sum16;

    always_comb begin
        if (r_gyro > GYRO_LIMIT) begin
            g = GYRO_LIMIT;
        end else if (r_gyro < -GYRO_LIMIT) begin
            g = -GYRO_LIMIT;
        end else begin
            g = r_gyro;
        end
        diff = {r_sp[15], r_sp} - {g[15], g};
        e    = diff[15:0];
        d0   = {e[15], e} - {r_prior[15], r_prior};
        dsum = {{2{d0[16]}}, d0} + {{2{r_dp1[16]}}, r_dp1} + {{2{r_dp2[16]}}, r_dp2};

        case (r_state)
            S_MDT: begin
                mul_a = $signed(r_dt);
                mul_b = {r_e[15], r_e};
            end
            S_MKI: begin
                mul_a = r_prod >>> DT_SHIFT;
                mul_b = $signed({1'b0, i_gains.ki});
            end
            S_MKP: begin
                mul_a = {{16{r_e[15]}}, r_e};
                mul_b = $signed({1'b0, i_gains.kp});
            end
            S_MKD: begin
                mul_a = {{13{r_dsum[18]}}, r_dsum};
                mul_b = $signed({1'b0, i_gains.kd});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_full = mul_a * mul_b;

        integ_sum = {{(32-INTEG_W){r_integ[INTEG_W-1]}}, r_integ} + r_prod;
        if (integ_sum > INTEG_LIMIT) begin
            integ_clamped = INTEG_LIMIT;
        end else if (integ_sum < -INTEG_LIMIT) begin
            integ_clamped = -INTEG_LIMIT;
        end else begin
            integ_clamped = integ_sum;
        end

        sum16 = r_p + r_prod[23:8]
              + {{6{r_integ[INTEG_W-1]}}, r_integ[INTEG_W-1:13]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prior <= '0;
            r_integ <= '0;
            r_dp1   <= '0;
            r_dp2   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_sp    <= i_setpoint;
                        r_gyro  <= i_gyro;
                        r_dt    <= i_dt;
                        r_state <= S_ERR;
                        if (i_ctl.clear) begin
                            r_prior <= '0;
                            r_integ <= '0;
                            r_dp1   <= '0;
                            r_dp2   <= '0;
                        end
                    end
                end
                S_ERR: begin
                    r_e     <= e;
                    r_dsum  <= dsum;
                    r_prior <= e;
                    r_dp2   <= r_dp1;
                    r_dp1   <= d0;
                    r_state <= S_MDT;
                end
                S_MDT: begin
                    r_prod  <= prod_full[31:0];
                    r_state <= S_MKI;
                end
                S_MKI: begin
                    r_prod  <= prod_full[31:0];
                    r_state <= S_MKP;
                end
                S_MKP: begin
                    r_integ <= integ_clamped[INTEG_W-1:0];
                    r_prod  <= prod_full[31:0];
                    r_state <= S_MKD;
                end
                S_MKD: begin
                    r_p     <= r_prod[23:8];
                    r_prod  <= prod_full[31:0];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (sum16 > DRIVE_LIMIT) begin
                        r_drive <= DRIVE_LIMIT[9:0];
                    end else if (sum16 < -DRIVE_LIMIT) begin
                        r_drive <= 10'(-DRIVE_LIMIT);
                    end else begin
                        r_drive <= sum16[9:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_ctl.ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sts.done  = (r_state == S_DONE);
    assign o_sts.drive = r_drive;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == S_IDLE)
        else $error("lane started while busy");
    a_ack_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.ack |-> r_state == S_DONE)
        else $error("lane acknowledged before its result");
    a_integ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> (r_integ <= 23'sd2097152 && r_integ >= -23'sd2097152))
        else $error("integrator outside its limit");
`endif

endmodule

// ===== rtl/trp_merge.sv =====
// merging stage: collects the three lane drives into the response register
// uses trp_pkg and trp_rsp_if
module trp_merge
    import trp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_lane_sts [AXES-1:0]  i_sts,
    output logic                  o_ack,
    trp_rsp_if.source             o_rsp
);

    logic              r_valid;
    logic signed [9:0] r_drive_x;
    logic signed [9:0] r_drive_y;
    logic signed [9:0] r_drive_z;
    logic              all_done;

    assign all_done = i_sts[0].done & i_sts[1].done & i_sts[2].done;
    assign o_ack    = all_done & (!r_valid | o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (o_ack) begin
                r_valid   <= 1'b1;
                r_drive_x <= i_sts[0].drive;
                r_drive_y <= i_sts[1].drive;
                r_drive_z <= i_sts[2].drive;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid   = r_valid;
    assign o_rsp.drive_x = r_drive_x;
    assign o_rsp.drive_y = r_drive_y;
    assign o_rsp.drive_z = r_drive_z;

endmodule

// ===== sim/three_axis_rate_pid_tb.sv =====
// self-checking testbench for the three-axis rate pid controller
// drives requests through trp_req_if, checks drives from trp_rsp_if against its own pid predictor
// depends on trp_pkg, trp_req_if, trp_rsp_if and three_axis_rate_pid
module three_axis_rate_pid_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import trp_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 320;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [47:0] GAINS_ALL_ONES = 48'hFFFF_FFFF_FFFF;

    localparam int GYRO_CLAMP  = 8000;
    localparam int INTEG_CLAMP = 2097152;
    localparam int DRIVE_CLAMP = 500;
    localparam int DT_SH       = 11;
    localparam int I_SH        = 13;
    localparam int PD_SH       = 8;

    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_LONG = 2;

    localparam int GAIN_TYPICAL = 0;
    localparam int GAIN_FULL    = 1;
    localparam int GAIN_MAX     = 2;
    localparam int GAIN_MIXED   = 3;

    typedef struct packed {
        logic signed [15:0] sp_x;
        logic signed [15:0] sp_y;
        logic signed [15:0] sp_z;
        logic signed [15:0] gy_x;
        logic signed [15:0] gy_y;
        logic signed [15:0] gy_z;
        logic [31:0]        stamp;
        logic               clr;
    } t_pid_req;

    typedef struct packed {
        logic signed [9:0] x;
        logic signed [9:0] y;
        logic signed [9:0] z;
    } t_drive_set;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    trp_req_if req_if();
    trp_rsp_if rsp_if();

    three_axis_rate_pid u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // predictor state
    logic [47:0] gains_m [3];
    logic [31:0] last_stamp_m;
    int          prior_err_m [3];
    int          integ_m [3];
    int          dlt1_m [3];
    int          dlt2_m [3];

    t_pid_req   pending_req_q [$];
    t_drive_set drive_expect_q [$];
    t_pid_req   held_req;
    logic [31:0] gen_stamp;

    int items_queued = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int gap_left     = 0;
    int burst_left   = 0;
    int rx_mode      = RX_FREE;
    int mode_left    = 0;
    int stall_left   = 0;

    function automatic int low16(input int v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    function automatic int clamp_int(input int v, input int lim);
        if (v < -lim) return -lim;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic t_drive_set pid_step(input t_pid_req r);
        int sp [3];
        int gy [3];
        int drv [3];
        int dt, g, e, kp, ki, kd, acc, d0, dsum, p, ival, d, sum;
        t_drive_set res;
        sp[0] = int'($signed(r.sp_x));
        sp[1] = int'($signed(r.sp_y));
        sp[2] = int'($signed(r.sp_z));
        gy[0] = int'($signed(r.gy_x));
        gy[1] = int'($signed(r.gy_y));
        gy[2] = int'($signed(r.gy_z));
        dt = int'(r.stamp - last_stamp_m);
        for (int a = 0; a < 3; a++) begin
            if (r.clr) begin
                prior_err_m[a] = 0;
                integ_m[a]     = 0;
                dlt1_m[a]      = 0;
                dlt2_m[a]      = 0;
            end
            kp  = int'(gains_m[a][15:0]);
            ki  = int'(gains_m[a][31:16]);
            kd  = int'(gains_m[a][47:32]);
            g   = clamp_int(gy[a], GYRO_CLAMP);
            e   = low16(sp[a] - g);
            acc = ((e * dt) >>> DT_SH) * ki;
            integ_m[a] = clamp_int(integ_m[a] + acc, INTEG_CLAMP);
            d0   = e - prior_err_m[a];
            prior_err_m[a] = e;
            dsum = d0 + dlt1_m[a] + dlt2_m[a];
            dlt2_m[a] = dlt1_m[a];
            dlt1_m[a] = d0;
            p    = low16((e * kp) >>> PD_SH);
            ival = integ_m[a] >>> I_SH;
            d    = low16((dsum * kd) >>> PD_SH);
            sum  = low16(p + ival + d);
            drv[a] = clamp_int(sum, DRIVE_CLAMP);
        end
        last_stamp_m = r.stamp;
        res.x = drv[0][9:0];
        res.y = drv[1][9:0];
        res.z = drv[2][9:0];
        return res;
    endfunction

    function automatic t_pid_req mk_req(input int sx, input int sy, input int sz,
                                        input int gx, input int gy, input int gz,
                                        input logic [31:0] stamp, input logic clr);
        t_pid_req r;
        r.sp_x  = 16'(sx);
        r.sp_y  = 16'(sy);
        r.sp_z  = 16'(sz);
        r.gy_x  = 16'(gx);
        r.gy_y  = 16'(gy);
        r.gy_z  = 16'(gz);
        r.stamp = stamp;
        r.clr   = clr;
        return r;
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return -8001;
            3: return 8001;
            4: return -8000;
            5: return 8000;
            6: return 0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [47:0] pick_gains(input int mode, input int axis);
        logic [47:0] v;
        case (mode)
            GAIN_TYPICAL: begin
                v = {16'($urandom_range(0, 2047)), 16'($urandom_range(0, 1023)),
                     16'($urandom_range(0, 4095))};
            end
            GAIN_FULL: begin
                v = {16'($urandom), 32'($urandom)};
            end
            GAIN_MAX: begin
                v = GAINS_ALL_ONES;
            end
            default: begin
                if (axis == 0) v = '0;
                else if (axis == 1) v = GAINS_ALL_ONES;
                else v = {16'($urandom), 32'($urandom)};
            end
        endcase
        return v;
    endfunction

    task automatic queue_req(input t_pid_req r);
        pending_req_q.push_back(r);
        items_queued++;
    endtask

    task automatic queue_random_req();
        int kind;
        int sp [3];
        int gy [3];
        logic clr;
        kind = $urandom_range(0, 99);
        clr  = 1'b0;
        if (kind < 85) begin
            // well-formed control loop step
            gen_stamp += 32'($urandom_range(50, 4000));
            clr = ($urandom_range(0, 63) == 0);
            for (int a = 0; a < 3; a++) begin
                if ($urandom_range(0, 7) == 0) sp[a] = low16(int'($urandom));
                else sp[a] = int'($urandom_range(0, 4000)) - 2000;
                gy[a] = sp[a] + int'($urandom_range(0, 600)) - 300;
            end
        end else if (kind < 95) begin
            gen_stamp = $urandom;
            clr = ($urandom_range(0, 3) == 0);
            for (int a = 0; a < 3; a++) begin
                sp[a] = low16(int'($urandom));
                gy[a] = low16(int'($urandom));
            end
        end else begin
            // timestamp steps back or jumps far ahead
            if ($urandom_range(0, 1) == 0) gen_stamp -= 32'($urandom_range(1, 20000));
            else gen_stamp += 32'($urandom_range(100000, 2000000000));
            for (int a = 0; a < 3; a++) begin
                sp[a] = pick_extreme();
                gy[a] = pick_extreme();
            end
        end
        queue_req(mk_req(sp[0], sp[1], sp[2], gy[0], gy[1], gy[2], gen_stamp, clr));
    endtask

    task automatic write_gains(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx <= CFG_GAINS_Z) gains_m[idx] = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do @(posedge i_clk); while (results_seen != items_queued);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_drive(input string axis, input logic signed [9:0] want,
                               input logic signed [9:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("drive_%s mismatch: expected %0d, got %0d", axis, want, got);
        end
    endtask

    // request driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
        end else begin
            if (req_if.valid && req_if.ready) drive_expect_q.push_back(pid_step(held_req));
            if (!req_if.valid || req_if.ready) begin
                if (gap_left > 0 || pending_req_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    req_if.valid <= 1'b0;
                end else begin
                    held_req = pending_req_q.pop_front();
                    req_if.setpoint_x      <= held_req.sp_x;
                    req_if.setpoint_y      <= held_req.sp_y;
                    req_if.setpoint_z      <= held_req.sp_z;
                    req_if.gyro_x          <= held_req.gy_x;
                    req_if.gyro_y          <= held_req.gy_y;
                    req_if.gyro_z          <= held_req.gy_z;
                    req_if.current_time_us <= held_req.stamp;
                    req_if.clear_state     <= held_req.clr;
                    req_if.valid           <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
        end
    end

    // response monitor and receiver stall pattern
    always @(posedge i_clk) begin
        t_drive_set want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (drive_expect_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected response: drives %0d %0d %0d",
                                 rsp_if.drive_x, rsp_if.drive_y, rsp_if.drive_z);
                end else begin
                    want = drive_expect_q.pop_front();
                    results_seen++;
                    check_drive("x", want.x, rsp_if.drive_x);
                    check_drive("y", want.y, rsp_if.drive_y);
                    check_drive("z", want.z, rsp_if.drive_z);
                end
            end
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(RX_FREE, RX_LONG);
                mode_left = $urandom_range(50, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_FREE: rsp_if.ready <= 1'b1;
                RX_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        rsp_if.ready <= 1'b0;
                    end else begin
                        rsp_if.ready <= 1'b1;
                        stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 20) : 0;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("three_axis_rate_pid_tb: done, errors");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        req_if.valid           = 1'b0;
        req_if.setpoint_x      = '0;
        req_if.setpoint_y      = '0;
        req_if.setpoint_z      = '0;
        req_if.gyro_x          = '0;
        req_if.gyro_y          = '0;
        req_if.gyro_z          = '0;
        req_if.current_time_us = '0;
        req_if.clear_state     = 1'b0;
        rsp_if.ready           = 1'b0;
        last_stamp_m = '0;
        for (int a = 0; a < 3; a++) begin
            gains_m[a]     = '0;
            prior_err_m[a] = 0;
            integ_m[a]     = 0;
            dlt1_m[a]      = 0;
            dlt2_m[a]      = 0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset gains; first step measures dt from a zero timestamp
        queue_req(mk_req(100, -200, 300, 0, 0, 0, 32'd1000, 1'b0));
        queue_req(mk_req(32767, -32768, 0, -32768, 32767, 8001, 32'd2000, 1'b0));
        wait_idle();

        write_gains(CFG_GAINS_X, {16'h0200, 16'h0100, 16'h0180});
        write_gains(CFG_GAINS_Y, {16'h0040, 16'h0800, 16'h0400});
        write_gains(CFG_GAINS_Z, {16'h1000, 16'h0020, 16'h0100});
        write_gains(CFG_SPARE, GAINS_ALL_ONES);

        queue_req(mk_req(0, 0, 0, 0, 0, 0, 32'd3000, 1'b1));
        queue_req(mk_req(32767, -32768, 32767, -32768, 32767, -8000, 32'd4000, 1'b0));
        queue_req(mk_req(-32768, 32767, -32768, 32767, -32768, 8000, 32'd5000, 1'b0));
        queue_req(mk_req(0, 0, 0, 8001, -8001, 7999, 32'd6000, 1'b0));
        queue_req(mk_req(1000, -1000, 500, 0, 0, 0, 32'd5500, 1'b0));
        queue_req(mk_req(30000, -30000, 20000, -8000, 8000, 0, 32'h7FFF_157C, 1'b0));
        queue_req(mk_req(30000, -30000, 20000, -8000, 8000, 0, 32'h7FFF_1964, 1'b0));
        queue_req(mk_req(-5, 5, 0, 0, 0, 0, 32'hFFFF_FF00, 1'b0));
        queue_req(mk_req(-5, 5, 0, 0, 0, 0, 32'h0000_0100, 1'b0));
        queue_req(mk_req(32767, -32768, 32767, 0, 0, 0, 32'h0000_02F4, 1'b0));
        queue_req(mk_req(-32768, 32767, -32768, 0, 0, 0, 32'h0000_04E8, 1'b0));
        queue_req(mk_req(32767, -32768, 32767, 0, 0, 0, 32'h0000_06DC, 1'b0));
        queue_req(mk_req(-32768, 32767, -32768, 0, 0, 0, 32'h0000_08D0, 1'b0));
        queue_req(mk_req(32767, -32768, 32767, -8000, 8000, -8000, 32'h0000_0AC4, 1'b1));
        queue_req(mk_req(200, 300, -400, 0, 0, 0, 32'h0000_0AC4, 1'b0));
        queue_req(mk_req(0, 0, 0, 0, 0, 0, 32'h0000_0CB8, 1'b0));
        wait_idle();

        for (int a = 0; a < 3; a++) write_gains(CFG_IDX_W'(a), GAINS_ALL_ONES);
        queue_req(mk_req(32767, 32767, 32767, -8000, -8000, -8000, 32'h0000_1000, 1'b0));
        queue_req(mk_req(-32768, -32768, -32768, 8000, 8000, 8000, 32'h0000_2000, 1'b0));
        queue_req(mk_req(1234, -4321, 77, -99, 8500, -8500, 32'h8000_2000, 1'b0));
        queue_req(mk_req(-1, 1, -1, 0, 0, 0, 32'h8000_3000, 1'b1));
        gen_stamp = 32'h8000_3000;

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            for (int a = 0; a < 3; a++)
                write_gains(CFG_IDX_W'(a), pick_gains(ph % (GAIN_MIXED + 1), a));
            if (ph == 1) write_gains(CFG_SPARE, '0);
            for (int n = 0; n < PHASE_ITEMS; n++) queue_random_req();
        end

        wait_idle();
        if (mismatches == 0 && drive_expect_q.size() == 0) begin
            $display("three_axis_rate_pid_tb: done, clean");
        end else begin
            $display("three_axis_rate_pid_tb: done, errors");
        end
        $finish;
    end

endmodule
